[hdl/rmq_pkg.sv]
// rmq_pkg: shared widths and constants for the rotation-matrix-to-quaternion unit
// used by rmq_sqrt, rmq_div and rotation_matrix_to_quaternion_unit; no dependencies
package rmq_pkg;

  // field format: signed Q2.30
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 30;

  // sums and differences of two fields, and of three fields
  localparam int NUM_W   = DATA_W + 1;
  localparam int TRACE_W = DATA_W + 2;
  // root argument with the constant one added, and clamped to non-negative
  localparam int ARGS_W  = TRACE_W + 1;
  localparam int ARG_W   = DATA_W + 1;

  // square root: 64-bit radicand, 32-bit root, two radicand bits per step
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int SQ_REM_W = SQ_OUT_W + 2;

  // restoring divider: 33-bit magnitudes, one quotient bit per step
  localparam int DIV_W = DATA_W + 1;
  localparam int QUO_W = FRAC_BITS + 1;

  // saturation bound and the fixed-point one
  localparam logic [DATA_W-1:0] COMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] ONE_Q    = DATA_W'(1) << FRAC_BITS;
  localparam logic [ARGS_W-1:0] ARG_ONE  = ARGS_W'(1) << FRAC_BITS;

endpackage

[hdl/rmq_sqrt.sv]
// rmq_sqrt: pipelined integer square root, floor(sqrt(v)), one root bit per stage
// depends on rmq_pkg; every stage is frozen while en is low
module rmq_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rmq_pkg::SQ_IN_W-1:0]  v,
  output logic [rmq_pkg::SQ_OUT_W-1:0] root
);

  localparam int STEPS = rmq_pkg::SQ_OUT_W;
  localparam int IN_W  = rmq_pkg::SQ_IN_W;
  localparam int REM_W = rmq_pkg::SQ_REM_W;

  logic [REM_W-1:0]  rem_r  [0:STEPS-2];
  logic [IN_W-1:0]   v_r    [0:STEPS-2];
  logic [STEPS-1:0]  root_r [0:STEPS-1];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      logic [REM_W-1:0] rem_i;
      logic [IN_W-1:0]  v_i;
      logic [STEPS-1:0] root_i;
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             hit;

      // stage input: module port for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
        assign rem_i  = '0;
        assign v_i    = v;
        assign root_i = '0;
      end else begin : g_next
        assign rem_i  = rem_r[k-1];
        assign v_i    = v_r[k-1];
        assign root_i = root_r[k-1];
      end

      // bring down two radicand bits and try 4*root + 1
      always_comb begin
        cur   = {rem_i, v_i[IN_W-1 -: 2]};
        trial = {2'b00, root_i, 2'b01};
        diff  = cur - trial;
        hit   = (cur >= trial);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[k] <= {root_i[STEPS-2:0], hit};
        end
      end

      if (k < STEPS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k] <= hit ? diff[REM_W-1:0] : cur[REM_W-1:0];
            v_r[k]   <= {v_i[IN_W-3:0], 2'b00};
          end
        end
      end
    end
  endgenerate

  assign root = root_r[STEPS-1];

endmodule

[hdl/rmq_div.sv]
// rmq_div: pipelined restoring divider, q = (a * 2^FRAC_BITS) / d for q below 2^QUO_W
// depends on rmq_pkg; every stage is frozen while en is low
module rmq_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rmq_pkg::DIV_W-1:0] a,
  input  logic [rmq_pkg::DIV_W-1:0] d,
  output logic [rmq_pkg::QUO_W-1:0] q
);

  localparam int STEPS = rmq_pkg::QUO_W;
  localparam int W     = rmq_pkg::DIV_W;

  logic [W-1:0]     rem_r [0:STEPS-2];
  logic [W-1:0]     d_r   [0:STEPS-2];
  logic [STEPS-1:0] q_r   [0:STEPS-1];

  genvar j;
  generate
    for (j = 0; j < STEPS; j++) begin : g_step
      logic [W-1:0]     rem_i;
      logic [W-1:0]     d_i;
      logic [STEPS-1:0] q_i;
      logic             fb;
      logic [W:0]       cur;
      logic [W:0]       diff;
      logic             hit;

      // the dividend is a shifted up by FRAC_BITS: only its low bit is fed in,
      // at the top quotient bit, the rest are zeros
      if (j == 0) begin : g_first
        assign rem_i = {1'b0, a[W-1:1]};
        assign d_i   = d;
        assign q_i   = '0;
        assign fb    = a[0];
      end else begin : g_next
        assign rem_i = rem_r[j-1];
        assign d_i   = d_r[j-1];
        assign q_i   = q_r[j-1];
        assign fb    = 1'b0;
      end

      // one compare and subtract per quotient bit
      always_comb begin
        cur  = {rem_i, fb};
        diff = cur - {1'b0, d_i};
        hit  = (cur >= {1'b0, d_i});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[j] <= {q_i[STEPS-2:0], hit};
        end
      end

      if (j < STEPS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[j] <= hit ? diff[W-1:0] : cur[W-1:0];
            d_r[j]   <= d_i;
          end
        end
      end
    end
  endgenerate

  assign q = q_r[STEPS-1];

endmodule

[hdl/rotation_matrix_to_quaternion_unit.sv]
// rotation_matrix_to_quaternion_unit: 3x3 rotation matrix to unit quaternion
// (Shepperd's method), fully pipelined; depends on rmq_pkg, rmq_sqrt, rmq_div
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_ready, r00 .. r22   | in
//   output  | out_valid, out_ready, qx .. qw   | out
//
// one item enters per cycle while the pipeline advances; on its way from acceptance to
// output each item passes two square roots of 32 stages, two divider banks of 31 stages and nine
// stages of selection, scaling, squaring and summing
// the whole pipeline advances when the output register is empty or taken,
// otherwise every stage holds; reset clears the valid bits only
module rotation_matrix_to_quaternion_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rmq_pkg::DATA_W-1:0] r00,
  input  logic signed [rmq_pkg::DATA_W-1:0] r01,
  input  logic signed [rmq_pkg::DATA_W-1:0] r02,
  input  logic signed [rmq_pkg::DATA_W-1:0] r10,
  input  logic signed [rmq_pkg::DATA_W-1:0] r11,
  input  logic signed [rmq_pkg::DATA_W-1:0] r12,
  input  logic signed [rmq_pkg::DATA_W-1:0] r20,
  input  logic signed [rmq_pkg::DATA_W-1:0] r21,
  input  logic signed [rmq_pkg::DATA_W-1:0] r22,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rmq_pkg::DATA_W-1:0] qx,
  output logic signed [rmq_pkg::DATA_W-1:0] qy,
  output logic signed [rmq_pkg::DATA_W-1:0] qz,
  output logic signed [rmq_pkg::DATA_W-1:0] qw
);

  localparam int DW   = rmq_pkg::DATA_W;
  localparam int NW   = rmq_pkg::NUM_W;
  localparam int TW   = rmq_pkg::TRACE_W;
  localparam int AW   = rmq_pkg::ARG_W;
  localparam int SW   = rmq_pkg::SQ_OUT_W;
  localparam int VW   = rmq_pkg::SQ_IN_W;
  localparam int DVW  = rmq_pkg::DIV_W;
  localparam int QW   = rmq_pkg::QUO_W;
  localparam int MW   = DW - 1;
  localparam int SQW  = 2 * MW;
  localparam int LAT  = 9 + 2 * SW + 2 * QW;

  // which component is the large one
  typedef enum logic [1:0] {BIG_X, BIG_Y, BIG_Z, BIG_W} big_t;

  typedef struct packed {
    big_t                  big;
    logic [2:0][NW-1:0]    n;
  } side_a_t;

  typedef struct packed {
    big_t                  big;
    logic [QW-1:0]         half_root;
    logic [2:0]            sgn;
    logic [2:0]            nz;
    logic [2:0]            ovf;
  } side_b_t;

  typedef struct packed {
    logic [3:0][MW-1:0]    mag;
    logic [3:0]            sgn;
  } side_c_t;

  typedef struct packed {
    logic [3:0]            sgn;
    logic                  lz;
  } side_d_t;

  logic           en;
  logic [LAT-1:0] vld;

  // global advance: the output register is empty or being taken
  assign out_valid = vld[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: trace, diagonal differences and comparisons, off-diagonal sums and differences
  logic signed [TW-1:0] trace1, dx1, dy1, dz1;
  logic signed [NW-1:0] e21m12, e02m20, e10m01, s01p10, s02p20, s12p21;
  logic                 gt01, gt02, gt12;

  always_ff @(posedge clk) begin
    if (en) begin
      trace1 <= TW'(r00) + TW'(r11) + TW'(r22);
      dx1    <= TW'(r00) - TW'(r11) - TW'(r22);
      dy1    <= TW'(r11) - TW'(r00) - TW'(r22);
      dz1    <= TW'(r22) - TW'(r00) - TW'(r11);
      e21m12 <= NW'(r21) - NW'(r12);
      e02m20 <= NW'(r02) - NW'(r20);
      e10m01 <= NW'(r10) - NW'(r01);
      s01p10 <= NW'(r01) + NW'(r10);
      s02p20 <= NW'(r02) + NW'(r20);
      s12p21 <= NW'(r12) + NW'(r21);
      gt01   <= r00 > r11;
      gt02   <= r00 > r22;
      gt12   <= r11 > r22;
    end
  end

  // stage 2: branch choice, root argument and numerators
  big_t                             big2_c;
  logic signed [TW-1:0]             dsel2;
  logic signed [rmq_pkg::ARGS_W-1:0] args2;
  logic [2:0][NW-1:0]               n2_c;
  logic [AW-1:0]                    arg2;
  side_a_t                          sa2;

  always_comb begin
    if (trace1 > TW'(0)) begin
      big2_c = BIG_W;
    end else if (gt01 && gt02) begin
      big2_c = BIG_X;
    end else if (gt12) begin
      big2_c = BIG_Y;
    end else begin
      big2_c = BIG_Z;
    end
    unique case (big2_c)
      BIG_X: begin
        dsel2 = dx1;
        n2_c  = {e21m12, s02p20, s01p10};
      end
      BIG_Y: begin
        dsel2 = dy1;
        n2_c  = {e02m20, s12p21, s01p10};
      end
      BIG_Z: begin
        dsel2 = dz1;
        n2_c  = {e10m01, s12p21, s02p20};
      end
      default: begin
        dsel2 = trace1;
        n2_c  = {e10m01, e02m20, e21m12};
      end
    endcase
    args2 = $signed(rmq_pkg::ARG_ONE) + rmq_pkg::ARGS_W'(dsel2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg2    <= args2[rmq_pkg::ARGS_W-1] ? '0 : args2[AW-1:0];
      sa2.big <= big2_c;
      sa2.n   <= n2_c;
    end
  end

  // first square root: root of arg scaled by 2^FRAC_BITS
  logic [VW-1:0] va;
  logic [SW-1:0] root_a;

  assign va = {{(VW-AW-rmq_pkg::FRAC_BITS){1'b0}}, arg2, {rmq_pkg::FRAC_BITS{1'b0}}};

  rmq_sqrt u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .v    (va),
    .root (root_a)
  );

  side_a_t sa_dl [0:SW-1];
  side_a_t sa_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dl[0] <= sa2;
      for (int i = 1; i < SW; i++) begin
        sa_dl[i] <= sa_dl[i-1];
      end
    end
  end
  assign sa_o = sa_dl[SW-1];

  // stage 3: divisor s = 2*root, numerator magnitudes, saturation checks
  logic [DVW-1:0]        s3;
  logic [2:0][DVW-1:0]   mag3;
  side_b_t               sb3;

  always_ff @(posedge clk) begin
    if (en) begin
      s3            <= {root_a, 1'b0};
      sb3.big       <= sa_o.big;
      sb3.half_root <= root_a[SW-1:1];
      for (int i = 0; i < 3; i++) begin
        logic [DVW-1:0] m;
        m = sa_o.n[i][NW-1] ? (DVW'(0) - sa_o.n[i]) : sa_o.n[i];
        mag3[i]       <= m;
        sb3.sgn[i]    <= sa_o.n[i][NW-1];
        sb3.nz[i]     <= (sa_o.n[i] != '0);
        sb3.ovf[i]    <= (root_a == '0) || ({1'b0, m} >= {root_a, 2'b00});
      end
    end
  end

  // numerator over s, three lanes
  logic [2:0][QW-1:0] qa;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_div_a
      rmq_div u_div (
        .clk (clk),
        .en  (en),
        .a   (mag3[g]),
        .d   (s3),
        .q   (qa[g])
      );
    end
  endgenerate

  side_b_t sb_dl [0:QW-1];
  side_b_t sb_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dl[0] <= sb3;
      for (int i = 1; i < QW; i++) begin
        sb_dl[i] <= sb_dl[i-1];
      end
    end
  end
  assign sb_o = sb_dl[QW-1];

  // stage 4: saturate, sign, and place components in x, y, z, w order
  logic [2:0][DW-1:0] lv4;
  logic [DW-1:0]      lg4;
  logic [DW-1:0]      q4 [0:3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sb_o.ovf[i]) begin
        lv4[i] = !sb_o.nz[i] ? '0 :
                 (sb_o.sgn[i] ? (DW'(0) - rmq_pkg::COMP_MAX) : rmq_pkg::COMP_MAX);
      end else begin
        lv4[i] = sb_o.sgn[i] ? (DW'(0) - {1'b0, qa[i]}) : {1'b0, qa[i]};
      end
    end
    lg4 = {1'b0, sb_o.half_root};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (sb_o.big)
        BIG_X: begin
          q4[0] <= lg4;    q4[1] <= lv4[0]; q4[2] <= lv4[1]; q4[3] <= lv4[2];
        end
        BIG_Y: begin
          q4[0] <= lv4[0]; q4[1] <= lg4;    q4[2] <= lv4[1]; q4[3] <= lv4[2];
        end
        BIG_Z: begin
          q4[0] <= lv4[0]; q4[1] <= lv4[1]; q4[2] <= lg4;    q4[3] <= lv4[2];
        end
        default: begin
          q4[0] <= lv4[0]; q4[1] <= lv4[1]; q4[2] <= lv4[2]; q4[3] <= lg4;
        end
      endcase
    end
  end

  // stages 5 to 8: magnitudes, squares, and the sum of squares
  logic [MW-1:0]    mag5 [0:3];
  logic [MW-1:0]    mag6 [0:3];
  logic [MW-1:0]    mag7 [0:3];
  logic [3:0]       sgn5, sgn6, sgn7;
  logic [SQW-1:0]   sq6  [0:3];
  logic [SQW:0]     p7   [0:1];
  logic [VW-1:0]    sum8;
  side_c_t          sc8;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [DW-1:0] neg;
        neg     = DW'(0) - q4[i];
        mag5[i] <= q4[i][DW-1] ? neg[MW-1:0] : q4[i][MW-1:0];
        sgn5[i] <= q4[i][DW-1];
        sq6[i]  <= SQW'(mag5[i] * mag5[i]);
        mag6[i] <= mag5[i];
        sgn6[i] <= sgn5[i];
        mag7[i] <= mag6[i];
        sgn7[i] <= sgn6[i];
        sc8.mag[i] <= mag7[i];
        sc8.sgn[i] <= sgn7[i];
      end
      p7[0] <= (SQW+1)'(sq6[0]) + (SQW+1)'(sq6[1]);
      p7[1] <= (SQW+1)'(sq6[2]) + (SQW+1)'(sq6[3]);
      sum8  <= VW'(p7[0]) + VW'(p7[1]);
    end
  end

  // second square root: the quaternion length
  logic [SW-1:0] len_b;

  rmq_sqrt u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .v    (sum8),
    .root (len_b)
  );

  side_c_t sc_dl [0:SW-1];
  side_c_t sc_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_dl[0] <= sc8;
      for (int i = 1; i < SW; i++) begin
        sc_dl[i] <= sc_dl[i-1];
      end
    end
  end
  assign sc_o = sc_dl[SW-1];

  // normalize: each magnitude over the length, four lanes
  logic [3:0][QW-1:0] qb;
  logic [DVW-1:0]     len_d;

  assign len_d = {1'b0, len_b};

  generate
    for (g = 0; g < 4; g++) begin : g_div_b
      rmq_div u_div (
        .clk (clk),
        .en  (en),
        .a   ({{(DVW-MW){1'b0}}, sc_o.mag[g]}),
        .d   (len_d),
        .q   (qb[g])
      );
    end
  endgenerate

  side_d_t sd_in;
  side_d_t sd_dl [0:QW-1];
  side_d_t sd_o;

  assign sd_in.sgn = sc_o.sgn;
  assign sd_in.lz  = (len_b == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      sd_dl[0] <= sd_in;
      for (int i = 1; i < QW; i++) begin
        sd_dl[i] <= sd_dl[i-1];
      end
    end
  end
  assign sd_o = sd_dl[QW-1];

  // output register: signed result, identity for a zero length
  logic [DW-1:0] qo [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (sd_o.lz) begin
          qo[i] <= (i == 3) ? rmq_pkg::ONE_Q : '0;
        end else begin
          qo[i] <= sd_o.sgn[i] ? (DW'(0) - {1'b0, qb[i]}) : {1'b0, qb[i]};
        end
      end
    end
  end

  assign qx = $signed(qo[0]);
  assign qy = $signed(qo[1]);
  assign qz = $signed(qo[2]);
  assign qw = $signed(qo[3]);

endmodule
